// ===== rtl/mws_pkg.sv =====
// Shared constants, register codes and pipeline types of the mecanum wheel speed solver.
// No dependencies; the testbench imports it and every other file refers to it by scoped names.
package mws_pkg;

   // Kinematics constants
   localparam int WHEEL_RPM_LIMIT = 8500;
   localparam int DEG_PER_RAD_Q16 = 3755331;

   // Field widths
   localparam int CMD_W      = 16;
   localparam int LIMIT_W    = 15;
   localparam int DIST_W     = 12;
   localparam int SCALE_W    = 24;
   localparam int RPM_W      = 16;
   localparam int RPM_MAG_W  = 15;
   localparam int WRPM_LIM_W = 14;
   localparam int WHEELS     = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_ENABLE  = 3'd0,
      CSR_BASE_TRACK_SUM = 3'd1,
      CSR_CENTER_X       = 3'd2,
      CSR_CENTER_Y       = 3'd3,
      CSR_RPM_SCALE      = 3'd4,
      CSR_LIMIT_FORWARD  = 3'd5,
      CSR_LIMIT_SIDEWAYS = 3'd6,
      CSR_LIMIT_YAW      = 3'd7
   } csr_index_type;

   // Lever arm unit: arm = |S| * 2^31 / DEG_PER_RAD_Q16 by reciprocal plus one correction
   localparam int ARM_SUM_W       = 15;
   localparam int ARM_MAG_W       = 14;
   localparam int ARM_Q_W         = 23;
   localparam int ARM_W           = 24;
   localparam int ARM_FRAC        = 31;
   localparam int ARM_NUM_W       = ARM_MAG_W + ARM_FRAC;
   localparam int ARM_RECIP_SHIFT = 24;
   localparam int ARM_RECIP_W     = 34;
   localparam int ARM_PROD_W      = ARM_MAG_W + ARM_RECIP_W;
   localparam logic [ARM_RECIP_W-1:0] ARM_RECIP =
      ARM_RECIP_W'((64'd1 << (ARM_FRAC + ARM_RECIP_SHIFT)) / 64'(DEG_PER_RAD_Q16));
   localparam int ARM_LATENCY     = 4;

   // Wheel term and rpm conversion
   localparam int LIN_W     = CMD_W + 1;
   localparam int WPROD_W   = CMD_W + ARM_W;
   localparam int TERM_W    = 41;
   localparam int TMAG_W    = TERM_W - 1;
   localparam int TLO_W     = 24;
   localparam int THI_W     = TMAG_W - TLO_W;
   localparam int P1_W      = THI_W + SCALE_W;
   localparam int P0_W      = TLO_W + SCALE_W;
   localparam int RSUM_W    = P0_W + 1;
   localparam int RPM_RAW_W = P1_W - 8 + 1;

   // Desaturation divider
   localparam int DIVD_W     = RPM_MAG_W + WRPM_LIM_W;
   localparam int DIV_Q_W    = 16;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = DIV_Q_W / DIV_BITS;

   // Sign, magnitude and flag of the four wheels riding beside the divider
   typedef struct packed {
      logic [WHEELS-1:0][RPM_MAG_W-1:0] mag;
      logic [WHEELS-1:0]                neg;
      logic                             scaled;
   } wheel_side_type;

endpackage

// ===== rtl/mws_req_if.sv =====
// Command channel of the mecanum wheel speed solver: valid, ready and one velocity command.
// Depends on mws_pkg for field widths.
interface mws_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [mws_pkg::CMD_W-1:0]   cmd_forward;
   logic signed [mws_pkg::CMD_W-1:0]   cmd_sideways;
   logic signed [mws_pkg::CMD_W-1:0]   cmd_yaw;

   modport source (output valid, output cmd_forward, output cmd_sideways, output cmd_yaw,
                   input ready);
   modport sink   (input valid, input cmd_forward, input cmd_sideways, input cmd_yaw,
                   output ready);
endinterface

// ===== rtl/mws_rsp_if.sv =====
// Result channel of the mecanum wheel speed solver: four wheel speeds and the scaled flag.
// Depends on mws_pkg for field widths.
interface mws_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mws_pkg::RPM_W-1:0]   rpm_front_right;
   logic signed [mws_pkg::RPM_W-1:0]   rpm_front_left;
   logic signed [mws_pkg::RPM_W-1:0]   rpm_back_left;
   logic signed [mws_pkg::RPM_W-1:0]   rpm_back_right;
   logic                               was_scaled;

   modport source (output valid, output rpm_front_right, output rpm_front_left,
                   output rpm_back_left, output rpm_back_right, output was_scaled,
                   input ready);
   modport sink   (input valid, input rpm_front_right, input rpm_front_left,
                   input rpm_back_left, input rpm_back_right, input was_scaled,
                   output ready);
endinterface

// ===== rtl/mws_csr_if.sv =====
// Configuration write channel of the mecanum wheel speed solver: register index and data.
// Depends on mws_pkg for widths.
interface mws_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mws_pkg::CSR_IDX_W-1:0]      index;
   logic [mws_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mecanum_wheel_speed_solver_core.sv =====
// Mecanum wheel speed solver: clamp, inverse kinematics, rpm conversion, desaturation.
// Throughput one item per cycle, set by an 11-stage pipeline with per-stage stall.
// The lever arms come from a free-running 4-stage arm unit on the configuration registers:
// after reset and after each configuration write, req_bus.ready stays low while a settle counter runs down.
// Reset (synchronous, active high) empties the pipeline and restores register defaults.
module mecanum_wheel_speed_solver_core (
   input  logic        clock,
   input  logic        reset,
   mws_req_if.sink     req_bus,
   mws_rsp_if.source   rsp_bus,
   mws_csr_if.sink     csr_bus
);

   localparam int NSTAGE     = 7 + mws_pkg::DIV_STAGES;
   localparam int STG_DIV    = 6;
   localparam int STG_OUT    = NSTAGE - 1;
   localparam int SETTLE_W   = $clog2(mws_pkg::ARM_LATENCY + 1);
   localparam int FR = 0;
   localparam int FL = 1;
   localparam int BL = 2;
   localparam int BR = 3;

   // configuration registers
   logic                                offset_enable_ff;
   logic [mws_pkg::DIST_W-1:0]          base_track_sum_ff;
   logic signed [mws_pkg::DIST_W-1:0]   center_x_offset_ff;
   logic signed [mws_pkg::DIST_W-1:0]   center_y_offset_ff;
   logic [mws_pkg::SCALE_W-1:0]         rpm_scale_ff;
   logic [mws_pkg::LIMIT_W-1:0]         limit_forward_ff;
   logic [mws_pkg::LIMIT_W-1:0]         limit_sideways_ff;
   logic [mws_pkg::LIMIT_W-1:0]         limit_yaw_ff;
   logic [SETTLE_W-1:0]                 settle_ff, settle_in;

   // pipeline control
   logic [NSTAGE-1:0]                   vld_ff, vld_in;
   logic [NSTAGE-1:0]                   stage_en;
   logic                                req_take;

   // lever arms
   logic signed [mws_pkg::ARM_SUM_W-1:0] base_s, x2_s, y2_s;
   logic signed [mws_pkg::ARM_SUM_W-1:0] arm_sum [mws_pkg::WHEELS];
   logic signed [mws_pkg::ARM_W-1:0]     arm     [mws_pkg::WHEELS];

   // stage 0: clamped command
   logic signed [mws_pkg::CMD_W-1:0]    vx_ff, vy_ff, vw_ff, vx_in, vy_in, vw_in;
   // stage 1: linear part and yaw product
   logic signed [mws_pkg::LIN_W-1:0]    lin_ff  [mws_pkg::WHEELS];
   logic signed [mws_pkg::LIN_W-1:0]    lin_in  [mws_pkg::WHEELS];
   logic signed [mws_pkg::WPROD_W-1:0]  prod_ff [mws_pkg::WHEELS];
   logic signed [mws_pkg::WPROD_W-1:0]  prod_in [mws_pkg::WHEELS];
   // stage 2: wheel term magnitude
   logic [mws_pkg::TMAG_W-1:0]          tmag_ff [mws_pkg::WHEELS];
   logic [mws_pkg::TMAG_W-1:0]          tmag_in [mws_pkg::WHEELS];
   logic [mws_pkg::WHEELS-1:0]          tneg_ff, tneg_in;
   // stage 3: partial products with rpm_scale
   logic [mws_pkg::P1_W-1:0]            p1_ff [mws_pkg::WHEELS];
   logic [mws_pkg::P1_W-1:0]            p1_in [mws_pkg::WHEELS];
   logic [mws_pkg::P0_W-1:0]            p0_ff [mws_pkg::WHEELS];
   logic [mws_pkg::P0_W-1:0]            p0_in [mws_pkg::WHEELS];
   logic [mws_pkg::WHEELS-1:0]          pneg_ff;
   // stage 4: saturated rpm magnitude
   logic [mws_pkg::RPM_MAG_W-1:0]       rmag_ff [mws_pkg::WHEELS];
   logic [mws_pkg::RPM_MAG_W-1:0]       rmag_in [mws_pkg::WHEELS];
   logic [mws_pkg::WHEELS-1:0]          rneg_ff;
   // stage 5: divider operands
   logic [mws_pkg::WHEELS-1:0][mws_pkg::DIVD_W-1:0] dvd_ff, dvd_in;
   logic [mws_pkg::RPM_MAG_W-1:0]       dmax_ff, dmax_in;
   mws_pkg::wheel_side_type             side_ff, side_in;
   // divider output
   logic [mws_pkg::WHEELS-1:0][mws_pkg::DIV_Q_W-1:0] div_quot;
   mws_pkg::wheel_side_type             div_side;
   // output register
   logic signed [mws_pkg::RPM_W-1:0]    rpm_ff [mws_pkg::WHEELS];
   logic signed [mws_pkg::RPM_W-1:0]    rpm_in [mws_pkg::WHEELS];
   logic                                scaled_ff;

   function automatic logic signed [mws_pkg::CMD_W-1:0] clamp_mag(
      input logic signed [mws_pkg::CMD_W-1:0] v,
      input logic [mws_pkg::LIMIT_W-1:0]      lim
   );
      logic signed [mws_pkg::CMD_W:0] v_x, l_x;
      v_x = (mws_pkg::CMD_W + 1)'(v);
      l_x = signed'({2'b00, lim});
      if (v_x > l_x) begin
         return mws_pkg::CMD_W'(l_x);
      end else if (v_x < -l_x) begin
         return mws_pkg::CMD_W'(-l_x);
      end
      return v;
   endfunction

   // ---------------- configuration ----------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_enable_ff   <= 1'b0;
         base_track_sum_ff  <= '0;
         center_x_offset_ff <= '0;
         center_y_offset_ff <= '0;
         rpm_scale_ff       <= '0;
         limit_forward_ff   <= '1;
         limit_sideways_ff  <= '1;
         limit_yaw_ff       <= '1;
      end else if (csr_bus.valid) begin
         unique case (mws_pkg::csr_index_type'(csr_bus.index))
            mws_pkg::CSR_OFFSET_ENABLE:  offset_enable_ff   <= csr_bus.data[0];
            mws_pkg::CSR_BASE_TRACK_SUM: base_track_sum_ff  <= csr_bus.data[mws_pkg::DIST_W-1:0];
            mws_pkg::CSR_CENTER_X:       center_x_offset_ff <= csr_bus.data[mws_pkg::DIST_W-1:0];
            mws_pkg::CSR_CENTER_Y:       center_y_offset_ff <= csr_bus.data[mws_pkg::DIST_W-1:0];
            mws_pkg::CSR_RPM_SCALE:      rpm_scale_ff       <= csr_bus.data[mws_pkg::SCALE_W-1:0];
            mws_pkg::CSR_LIMIT_FORWARD:  limit_forward_ff   <= csr_bus.data[mws_pkg::LIMIT_W-1:0];
            mws_pkg::CSR_LIMIT_SIDEWAYS: limit_sideways_ff  <= csr_bus.data[mws_pkg::LIMIT_W-1:0];
            mws_pkg::CSR_LIMIT_YAW:      limit_yaw_ff       <= csr_bus.data[mws_pkg::LIMIT_W-1:0];
         endcase
      end
   end

   // hold off items until the arm pipeline reflects the current registers
   always_comb begin
      if (csr_bus.valid) begin
         settle_in = SETTLE_W'(mws_pkg::ARM_LATENCY);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_W'(mws_pkg::ARM_LATENCY);
      end else begin
         settle_ff <= settle_in;
      end
   end

   // ---------------- lever arms ----------------
   always_comb begin
      base_s = signed'(mws_pkg::ARM_SUM_W'(base_track_sum_ff));
      x2_s   = offset_enable_ff ? mws_pkg::ARM_SUM_W'({center_x_offset_ff, 1'b0}) : '0;
      y2_s   = offset_enable_ff ? mws_pkg::ARM_SUM_W'({center_y_offset_ff, 1'b0}) : '0;
      if (offset_enable_ff) begin
         x2_s = signed'({{2{center_x_offset_ff[mws_pkg::DIST_W-1]}}, center_x_offset_ff, 1'b0});
         y2_s = signed'({{2{center_y_offset_ff[mws_pkg::DIST_W-1]}}, center_y_offset_ff, 1'b0});
      end
      arm_sum[FR] = base_s - x2_s + y2_s;
      arm_sum[FL] = base_s - x2_s - y2_s;
      arm_sum[BL] = base_s + x2_s - y2_s;
      arm_sum[BR] = base_s + x2_s + y2_s;
   end

   for (genvar w = 0; w < mws_pkg::WHEELS; w++) begin : g_arm
      mws_arm u_arm (
         .clock   (clock),
         .arm_sum (arm_sum[w]),
         .arm     (arm[w])
      );
   end

   // ---------------- pipeline control ----------------
   always_comb begin
      stage_en[STG_OUT] = !vld_ff[STG_OUT] || rsp_bus.ready;
      for (int k = STG_OUT - 1; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      req_take = stage_en[0] && (settle_ff == '0);
      vld_in[0] = req_bus.valid && req_take;
      for (int k = 1; k < NSTAGE; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_bus.ready = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // ---------------- datapath ----------------
   always_comb begin
      logic signed [mws_pkg::LIN_W-1:0]    vx_x, vy_x;
      logic signed [mws_pkg::TERM_W-1:0]   term;
      logic [mws_pkg::RSUM_W-1:0]          low_sum;
      logic [mws_pkg::RPM_RAW_W-1:0]       raw;
      logic [mws_pkg::RPM_MAG_W-1:0]       m01, m23, mx, msel;

      vx_in = clamp_mag(req_bus.cmd_forward, limit_forward_ff);
      vy_in = clamp_mag(req_bus.cmd_sideways, limit_sideways_ff);
      vw_in = clamp_mag(req_bus.cmd_yaw, limit_yaw_ff);

      vx_x = mws_pkg::LIN_W'(vx_ff);
      vy_x = mws_pkg::LIN_W'(vy_ff);
      lin_in[FR] = -vx_x - vy_x;
      lin_in[FL] =  vx_x - vy_x;
      lin_in[BL] =  vx_x + vy_x;
      lin_in[BR] = -vx_x + vy_x;

      for (int w = 0; w < mws_pkg::WHEELS; w++) begin
         prod_in[w] = mws_pkg::WPROD_W'(vw_ff) * mws_pkg::WPROD_W'(arm[w]);

         term = signed'({{(mws_pkg::TERM_W - mws_pkg::LIN_W - 16){lin_ff[w][mws_pkg::LIN_W-1]}},
                         lin_ff[w], 16'h0000}) - mws_pkg::TERM_W'(prod_ff[w]);
         tneg_in[w] = term[mws_pkg::TERM_W-1];
         tmag_in[w] = tneg_in[w] ? mws_pkg::TMAG_W'(-term) : mws_pkg::TMAG_W'(term);

         p1_in[w] = mws_pkg::P1_W'(tmag_ff[w][mws_pkg::TMAG_W-1:mws_pkg::TLO_W]) *
                    mws_pkg::P1_W'(rpm_scale_ff);
         p0_in[w] = mws_pkg::P0_W'(tmag_ff[w][mws_pkg::TLO_W-1:0]) *
                    mws_pkg::P0_W'(rpm_scale_ff);

         // floor(mag * scale / 2^32) from the two partial products
         low_sum = mws_pkg::RSUM_W'({p1_ff[w][7:0], 24'h000000}) + mws_pkg::RSUM_W'(p0_ff[w]);
         raw = mws_pkg::RPM_RAW_W'(p1_ff[w][mws_pkg::P1_W-1:8]) +
               mws_pkg::RPM_RAW_W'(low_sum[mws_pkg::RSUM_W-1:32]);
         rmag_in[w] = (raw > mws_pkg::RPM_RAW_W'(32767)) ? '1 : raw[mws_pkg::RPM_MAG_W-1:0];

         dvd_in[w] = mws_pkg::DIVD_W'(rmag_ff[w]) * mws_pkg::DIVD_W'(mws_pkg::WHEEL_RPM_LIMIT);
      end

      m01 = (rmag_ff[0] > rmag_ff[1]) ? rmag_ff[0] : rmag_ff[1];
      m23 = (rmag_ff[2] > rmag_ff[3]) ? rmag_ff[2] : rmag_ff[3];
      mx  = (m01 > m23) ? m01 : m23;
      dmax_in = mx;
      for (int w = 0; w < mws_pkg::WHEELS; w++) begin
         side_in.mag[w] = rmag_ff[w];
      end
      side_in.neg    = rneg_ff;
      side_in.scaled = (mx > mws_pkg::RPM_MAG_W'(mws_pkg::WHEEL_RPM_LIMIT));

      for (int w = 0; w < mws_pkg::WHEELS; w++) begin
         msel = div_side.scaled ? div_quot[w][mws_pkg::RPM_MAG_W-1:0] : div_side.mag[w];
         rpm_in[w] = div_side.neg[w] ? -signed'(mws_pkg::RPM_W'(msel))
                                     :  signed'(mws_pkg::RPM_W'(msel));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vw_ff <= vw_in;
      end
      if (stage_en[1]) begin
         lin_ff  <= lin_in;
         prod_ff <= prod_in;
      end
      if (stage_en[2]) begin
         tmag_ff <= tmag_in;
         tneg_ff <= tneg_in;
      end
      if (stage_en[3]) begin
         p1_ff   <= p1_in;
         p0_ff   <= p0_in;
         pneg_ff <= tneg_ff;
      end
      if (stage_en[4]) begin
         rmag_ff <= rmag_in;
         rneg_ff <= pneg_ff;
      end
      if (stage_en[5]) begin
         dvd_ff  <= dvd_in;
         dmax_ff <= dmax_in;
         side_ff <= side_in;
      end
      if (stage_en[STG_OUT]) begin
         rpm_ff    <= rpm_in;
         scaled_ff <= div_side.scaled;
      end
   end

   mws_div u_div (
      .clock    (clock),
      .stage_en (stage_en[STG_DIV +: mws_pkg::DIV_STAGES]),
      .dividend (dvd_ff),
      .divisor  (dmax_ff),
      .side_in  (side_ff),
      .quot     (div_quot),
      .side_out (div_side)
   );

   assign rsp_bus.valid           = vld_ff[STG_OUT];
   assign rsp_bus.rpm_front_right = rpm_ff[FR];
   assign rsp_bus.rpm_front_left  = rpm_ff[FL];
   assign rsp_bus.rpm_back_left   = rpm_ff[BL];
   assign rsp_bus.rpm_back_right  = rpm_ff[BR];
   assign rsp_bus.was_scaled      = scaled_ff;

endmodule

// ===== rtl/mws_arm.sv =====
// Yaw lever arm of one wheel: signed Q8.16 arm = S * 2^31 / DEG_PER_RAD_Q16, truncated.
// Free-running 4-stage pipeline fed from configuration registers; depends on mws_pkg.
module mws_arm (
   input  logic                                  clock,
   input  logic signed [mws_pkg::ARM_SUM_W-1:0]  arm_sum,
   output logic signed [mws_pkg::ARM_W-1:0]      arm
);

   logic [mws_pkg::ARM_MAG_W-1:0]  amag_ff, amag_in;
   logic                           aneg_ff, aneg_in;
   logic [mws_pkg::ARM_Q_W-1:0]    q0_ff, q0_in;
   logic [mws_pkg::ARM_MAG_W-1:0]  bmag_ff;
   logic                           bneg_ff;
   logic [mws_pkg::ARM_Q_W-1:0]    q_ff, q_in;
   logic                           cneg_ff;
   logic signed [mws_pkg::ARM_W-1:0] arm_ff, arm_in;

   logic [mws_pkg::ARM_PROD_W-1:0] rprod;
   logic [mws_pkg::ARM_NUM_W-1:0]  num, qd, rem;

   always_comb begin
      aneg_in = arm_sum[mws_pkg::ARM_SUM_W-1];
      amag_in = aneg_in ? mws_pkg::ARM_MAG_W'(-arm_sum) : mws_pkg::ARM_MAG_W'(arm_sum);

      // estimate is exact or one short
      rprod = mws_pkg::ARM_PROD_W'(amag_ff) * mws_pkg::ARM_PROD_W'(mws_pkg::ARM_RECIP);
      q0_in = rprod[mws_pkg::ARM_RECIP_SHIFT +: mws_pkg::ARM_Q_W];

      num  = {bmag_ff, {mws_pkg::ARM_FRAC{1'b0}}};
      qd   = mws_pkg::ARM_NUM_W'(q0_ff) * mws_pkg::ARM_NUM_W'(mws_pkg::DEG_PER_RAD_Q16);
      rem  = num - qd;
      q_in = (rem >= mws_pkg::ARM_NUM_W'(mws_pkg::DEG_PER_RAD_Q16)) ?
             q0_ff + mws_pkg::ARM_Q_W'(1) : q0_ff;

      arm_in = cneg_ff ? -signed'(mws_pkg::ARM_W'(q_ff)) : signed'(mws_pkg::ARM_W'(q_ff));
   end

   always_ff @(posedge clock) begin
      amag_ff <= amag_in;
      aneg_ff <= aneg_in;
      q0_ff   <= q0_in;
      bmag_ff <= amag_ff;
      bneg_ff <= aneg_ff;
      q_ff    <= q_in;
      cneg_ff <= bneg_ff;
      arm_ff  <= arm_in;
   end

   assign arm = arm_ff;

endmodule

// ===== rtl/mws_div.sv =====
// Desaturation divider: four lanes of dividend / shared divisor, restoring, 4 quotient bits
// per stage over 4 stages, wheel side data carried alongside. Depends on mws_pkg.
module mws_div (
   input  logic                                                  clock,
   input  logic [mws_pkg::DIV_STAGES-1:0]                        stage_en,
   input  logic [mws_pkg::WHEELS-1:0][mws_pkg::DIVD_W-1:0]       dividend,
   input  logic [mws_pkg::RPM_MAG_W-1:0]                         divisor,
   input  mws_pkg::wheel_side_type                               side_in,
   output logic [mws_pkg::WHEELS-1:0][mws_pkg::DIV_Q_W-1:0]      quot,
   output mws_pkg::wheel_side_type                               side_out
);

   logic [mws_pkg::DIV_STAGES-1:0][mws_pkg::WHEELS-1:0][mws_pkg::RPM_MAG_W-1:0] rem_ff, rem_in;
   logic [mws_pkg::DIV_STAGES-1:0][mws_pkg::WHEELS-1:0][mws_pkg::DIV_Q_W-1:0]   low_ff, low_in;
   logic [mws_pkg::DIV_STAGES-1:0][mws_pkg::WHEELS-1:0][mws_pkg::DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [mws_pkg::DIV_STAGES-1:0][mws_pkg::RPM_MAG_W-1:0]                      dvs_ff, dvs_in;
   mws_pkg::wheel_side_type [mws_pkg::DIV_STAGES-1:0]                           side_ff, side_in_s;

   always_comb begin
      logic [mws_pkg::RPM_MAG_W-1:0] r;
      logic [mws_pkg::RPM_MAG_W:0]   r_sh;
      logic [mws_pkg::DIV_Q_W-1:0]   lo;
      logic [mws_pkg::DIV_Q_W-1:0]   q;
      logic [mws_pkg::RPM_MAG_W-1:0] d;
      for (int s = 0; s < mws_pkg::DIV_STAGES; s++) begin
         if (s == 0) begin
            d            = divisor;
            side_in_s[s] = side_in;
         end else begin
            d            = dvs_ff[s-1];
            side_in_s[s] = side_ff[s-1];
         end
         dvs_in[s] = d;
         for (int w = 0; w < mws_pkg::WHEELS; w++) begin
            if (s == 0) begin
               // quotient fits DIV_Q_W bits, so the top part starts below the divisor
               r  = mws_pkg::RPM_MAG_W'(dividend[w] >> mws_pkg::DIV_Q_W);
               lo = dividend[w][mws_pkg::DIV_Q_W-1:0];
               q  = '0;
            end else begin
               r  = rem_ff[s-1][w];
               lo = low_ff[s-1][w];
               q  = quot_ff[s-1][w];
            end
            for (int b = 0; b < mws_pkg::DIV_BITS; b++) begin
               r_sh = {r, lo[mws_pkg::DIV_Q_W-1]};
               lo   = {lo[mws_pkg::DIV_Q_W-2:0], 1'b0};
               if (r_sh >= {1'b0, d}) begin
                  r = mws_pkg::RPM_MAG_W'(r_sh - {1'b0, d});
                  q = {q[mws_pkg::DIV_Q_W-2:0], 1'b1};
               end else begin
                  r = r_sh[mws_pkg::RPM_MAG_W-1:0];
                  q = {q[mws_pkg::DIV_Q_W-2:0], 1'b0};
               end
            end
            rem_in[s][w]  = r;
            low_in[s][w]  = lo;
            quot_in[s][w] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < mws_pkg::DIV_STAGES; s++) begin
         if (stage_en[s]) begin
            rem_ff[s]  <= rem_in[s];
            low_ff[s]  <= low_in[s];
            quot_ff[s] <= quot_in[s];
            dvs_ff[s]  <= dvs_in[s];
            side_ff[s] <= side_in_s[s];
         end
      end
   end

   assign quot     = quot_ff[mws_pkg::DIV_STAGES-1];
   assign side_out = side_ff[mws_pkg::DIV_STAGES-1];

endmodule

// ===== verif/mecanum_wheel_speed_solver_core_tb.sv =====
// Self-checking testbench of the mecanum wheel speed solver core: a directed table, then random
// configurations and commands, scored against fixed expected values or a fixed-point predictor of the kinematics.
// Depends on mws_pkg, the three channel interfaces and mecanum_wheel_speed_solver_core.
module mecanum_wheel_speed_solver_core_tb;
   import mws_pkg::*;

   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 1030;
   localparam int DIR_ROWS      = 23;
   localparam int DIR_PHASES    = 6;

   typedef struct packed {
      logic signed [RPM_W-1:0] fr;
      logic signed [RPM_W-1:0] fl;
      logic signed [RPM_W-1:0] bl;
      logic signed [RPM_W-1:0] br;
      logic                    scaled;
   } wheel_speeds_t;

   typedef struct packed {
      logic [2:0]              phase;
      logic signed [CMD_W-1:0] fwd;
      logic signed [CMD_W-1:0] side;
      logic signed [CMD_W-1:0] yaw;
      logic                    fixed_want;
      wheel_speeds_t           want;
   } cmd_row_t;

   typedef struct packed {
      logic                     en;
      logic [DIST_W-1:0]        base;
      logic signed [DIST_W-1:0] cx;
      logic signed [DIST_W-1:0] cy;
      logic [SCALE_W-1:0]       scale;
      logic [LIMIT_W-1:0]       lim_fwd;
      logic [LIMIT_W-1:0]       lim_side;
      logic [LIMIT_W-1:0]       lim_yaw;
   } chassis_cfg_t;

   localparam wheel_speeds_t NO_SPEED = '0;

   logic clock = 1'b0;
   logic reset;

   mws_req_if req_bus ();
   mws_rsp_if rsp_bus ();
   mws_csr_if csr_bus ();

   mecanum_wheel_speed_solver_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // register shadow used by the predictor
   logic                     m_en;
   logic [DIST_W-1:0]        m_base;
   logic signed [DIST_W-1:0] m_cx;
   logic signed [DIST_W-1:0] m_cy;
   logic [SCALE_W-1:0]       m_scale;
   logic [LIMIT_W-1:0]       m_lim_fwd;
   logic [LIMIT_W-1:0]       m_lim_side;
   logic [LIMIT_W-1:0]       m_lim_yaw;

   cmd_row_t      cmd_q[$];
   wheel_speeds_t wheel_expect_q[$];
   cmd_row_t      dir_rows [DIR_ROWS];
   chassis_cfg_t  dir_cfgs [DIR_PHASES];

   int     mismatches = 0;
   int     results_seen = 0;
   int     burst_left = 0;
   int     gap_left = 0;
   int     hold_left = 0;
   int     stall_mode = 0;
   int     mode_left = 0;
   int     rsp_tick = 0;
   longint cycle_count = 0;

   function automatic longint clamp_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // arm = |S| * 2^31 / deg-per-rad, truncated toward zero, sign restored
   function automatic longint lever_arm_q16(longint s);
      longint unsigned mag;
      longint unsigned q;
      mag = (s < 0) ? -s : s;
      q = (mag << ARM_FRAC) / DEG_PER_RAD_Q16;
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return (s < 0) ? -longint'(q) : longint'(q);
   endfunction

   // magnitude times Q8.16 scale over 2^32, split so nothing overflows 64 bits
   function automatic longint term_to_rpm(longint t);
      longint unsigned mag;
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned p1;
      longint unsigned p0;
      longint unsigned r;
      mag = (t < 0) ? -t : t;
      hi = mag >> 24;
      lo = mag & 64'hFF_FFFF;
      p1 = hi * m_scale;
      p0 = lo * m_scale;
      r = (p1 >> 8) + ((((p1 & 64'hFF) << 24) + p0) >> 32);
      if (r > 32767) r = 32767;
      return (t < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic wheel_speeds_t mecanum_speeds(logic signed [CMD_W-1:0] fwd,
                                                    logic signed [CMD_W-1:0] side,
                                                    logic signed [CMD_W-1:0] yaw);
      longint vx;
      longint vy;
      longint vw;
      longint x2;
      longint y2;
      longint b;
      longint peak;
      longint mag;
      longint term [WHEELS];
      longint rpm [WHEELS];
      wheel_speeds_t r;
      vx = clamp_mag(fwd, m_lim_fwd);
      vy = clamp_mag(side, m_lim_side);
      vw = clamp_mag(yaw, m_lim_yaw);
      x2 = m_en ? 2 * longint'(m_cx) : 64'sd0;
      y2 = m_en ? 2 * longint'(m_cy) : 64'sd0;
      b = longint'(m_base);
      term[0] = (-vx - vy) * 65536 - vw * lever_arm_q16(b - x2 + y2);
      term[1] = ( vx - vy) * 65536 - vw * lever_arm_q16(b - x2 - y2);
      term[2] = ( vx + vy) * 65536 - vw * lever_arm_q16(b + x2 - y2);
      term[3] = (-vx + vy) * 65536 - vw * lever_arm_q16(b + x2 + y2);
      peak = 0;
      for (int i = 0; i < WHEELS; i++) begin
         rpm[i] = term_to_rpm(term[i]);
         mag = (rpm[i] < 0) ? -rpm[i] : rpm[i];
         if (mag > peak) peak = mag;
      end
      r.scaled = (peak > WHEEL_RPM_LIMIT);
      if (r.scaled) begin
         for (int i = 0; i < WHEELS; i++) begin
            mag = (rpm[i] < 0) ? -rpm[i] : rpm[i];
            mag = (mag * WHEEL_RPM_LIMIT) / peak;
            rpm[i] = (rpm[i] < 0) ? -mag : mag;
         end
      end
      r.fr = 16'(rpm[0]);
      r.fl = 16'(rpm[1]);
      r.bl = 16'(rpm[2]);
      r.br = 16'(rpm[3]);
      return r;
   endfunction

   function automatic void store_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_OFFSET_ENABLE:  m_en = data[0];
         CSR_BASE_TRACK_SUM: m_base = data[DIST_W-1:0];
         CSR_CENTER_X:       m_cx = data[DIST_W-1:0];
         CSR_CENTER_Y:       m_cy = data[DIST_W-1:0];
         CSR_RPM_SCALE:      m_scale = data[SCALE_W-1:0];
         CSR_LIMIT_FORWARD:  m_lim_fwd = data[LIMIT_W-1:0];
         CSR_LIMIT_SIDEWAYS: m_lim_side = data[LIMIT_W-1:0];
         CSR_LIMIT_YAW:      m_lim_yaw = data[LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // leaves valid high so back-to-back writes never lower and raise it in one step
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      store_reg(idx, data);
   endtask

   // junk fills the unused upper data bits, which the block must drop
   task automatic write_config(chassis_cfg_t c, bit junk);
      logic [31:0] j;
      j = junk ? $urandom() : 32'd0;
      write_reg(CSR_OFFSET_ENABLE,  {j[22:0], c.en});
      write_reg(CSR_BASE_TRACK_SUM, {j[11:0], c.base});
      write_reg(CSR_CENTER_X,       {j[11:0], c.cx});
      write_reg(CSR_CENTER_Y,       {j[11:0], c.cy});
      write_reg(CSR_RPM_SCALE,      c.scale);
      write_reg(CSR_LIMIT_FORWARD,  {j[8:0], c.lim_fwd});
      write_reg(CSR_LIMIT_SIDEWAYS, {j[8:0], c.lim_side});
      write_reg(CSR_LIMIT_YAW,      {j[8:0], c.lim_yaw});
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (cmd_q.size() != 0 || req_bus.valid || wheel_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [CMD_W-1:0] rand_cmd(logic [LIMIT_W-1:0] lim);
      int v;
      case ($urandom_range(0, 7))
         0, 1, 2: v = $urandom_range(0, 65535) - 32768;
         3:       v = $urandom_range(0, 1) ? 32767 : -32768;
         4:       v = $urandom_range(0, 40) - 20;
         5: begin
            // straddle the clamp point
            v = int'(lim) - 1 + $urandom_range(0, 2);
            if (v > 32767) v = 32767;
            if ($urandom_range(0, 1)) v = -v;
         end
         6:       v = 0;
         default: v = $urandom_range(0, 4000) - 2000;
      endcase
      return 16'(v);
   endfunction

   function automatic logic [LIMIT_W-1:0] rand_limit();
      case ($urandom_range(0, 7))
         0:       return '0;
         1, 2:    return 15'h7FFF;
         3:       return 15'($urandom());
         default: return 15'($urandom_range(100, 6000));
      endcase
   endfunction

   function automatic logic [DIST_W-1:0] rand_offset();
      case ($urandom_range(0, 3))
         0:       return 12'h800;
         1:       return 12'h7FF;
         2:       return 12'($urandom());
         default: return 12'($urandom_range(0, 200) - 100);
      endcase
   endfunction

   function automatic chassis_cfg_t rand_config();
      chassis_cfg_t c;
      c.en = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       c.base = '0;
         1:       c.base = 12'hFFF;
         2:       c.base = 12'($urandom());
         default: c.base = 12'($urandom_range(250, 700));
      endcase
      c.cx = rand_offset();
      c.cy = rand_offset();
      case ($urandom_range(0, 7))
         0:       c.scale = '0;
         1:       c.scale = 24'hFF_FFFF;
         2:       c.scale = 24'($urandom());
         default: c.scale = 24'($urandom_range(20000, 200000));
      endcase
      c.lim_fwd  = rand_limit();
      c.lim_side = rand_limit();
      c.lim_yaw  = rand_limit();
      return c;
   endfunction

   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endfunction

   // command sender: bursts of random length separated by random gaps
   always @(posedge clock) begin : req_side
      cmd_row_t done;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            done = cmd_q.pop_front();
            wheel_expect_q.push_back(done.fixed_want ? done.want :
                                     mecanum_speeds(done.fwd, done.side, done.yaw));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
               req_bus.valid        <= 1'b1;
               req_bus.cmd_forward  <= cmd_q[0].fwd;
               req_bus.cmd_sideways <= cmd_q[0].side;
               req_bus.cmd_yaw      <= cmd_q[0].yaw;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: checks each item, stalls on its own mode pattern plus long hold-offs
   always @(posedge clock) begin : rsp_side
      wheel_speeds_t got;
      wheel_speeds_t want;
      logic rdy;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.rpm_front_right, rsp_bus.rpm_front_left, rsp_bus.rpm_back_left,
                 rsp_bus.rpm_back_right, rsp_bus.was_scaled};
         results_seen++;
         if (wheel_expect_q.size() == 0) begin
            note_failure($sformatf("result %0d with no command pending: FR %0d FL %0d BL %0d BR %0d",
                                   results_seen, got.fr, got.fl, got.bl, got.br));
         end else begin
            want = wheel_expect_q.pop_front();
            if (got !== want)
               note_failure($sformatf({"result %0d: want FR %0d FL %0d BL %0d BR %0d scaled %0b,",
                                       " got FR %0d FL %0d BL %0d BR %0d scaled %0b"},
                                      results_seen, want.fr, want.fl, want.bl, want.br,
                                      want.scaled, got.fr, got.fl, got.bl, got.br, got.scaled));
         end
         // long hold-off lets the pipeline fill and push back on the sender
         if (results_seen == 150 || results_seen == 600 || $urandom_range(0, 299) == 0)
            hold_left = $urandom_range(40, 100);
      end
      rsp_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else begin
         case (stall_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ((rsp_tick % 3) != 0);
         endcase
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 80);
      end else begin
         mode_left--;
      end
      rsp_bus.ready <= rdy;
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      chassis_cfg_t cfg;
      cmd_row_t item;
      int n;
      int left;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd_forward = '0;
      req_bus.cmd_sideways = '0;
      req_bus.cmd_yaw = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_OFFSET_ENABLE;
      csr_bus.data = '0;

      m_en = 1'b0;
      m_base = '0;
      m_cx = '0;
      m_cy = '0;
      m_scale = '0;
      m_lim_fwd = 15'h7FFF;
      m_lim_side = 15'h7FFF;
      m_lim_yaw = 15'h7FFF;

      // phase 0 runs on the reset values and is never written
      dir_cfgs = '{
         '{0, 0,    0,     0,     0,        32767, 32767, 32767},
         '{0, 0,    0,     0,     65536,    32767, 32767, 32767},
         '{1, 4095, 2047,  -2048, 65536,    0,     0,     0},
         '{1, 0,    2047,  -2048, 65536,    32767, 1000,  500},
         '{0, 4095, -2048, 2047,  16777215, 32767, 32767, 32767},
         '{1, 450,  30,    -20,   156300,   3000,  3000,  180}
      };

      dir_rows = '{
         // zero scale after reset: every wheel stops
         '{0, 32767,  -32768, 1,      1, NO_SPEED},
         '{0, -32768, 32767,  -32768, 1, NO_SPEED},
         '{0, 0,      0,      0,      1, NO_SPEED},
         // unity scale, no lever arm
         '{1, 1000,   0,      0,      1, '{-1000, 1000, 1000, -1000, 0}},
         '{1, 0,      1000,   0,      1, '{-1000, -1000, 1000, 1000, 0}},
         '{1, -1,     0,      0,      1, '{1, -1, -1, 1, 0}},
         '{1, 0,      0,      32767,  1, NO_SPEED},
         '{1, 32767,  0,      0,      1, '{-8500, 8500, 8500, -8500, 1}},
         '{1, -32768, 0,      0,      1, '{8500, -8500, -8500, 8500, 1}},
         // two wheels overflow and saturate before desaturation
         '{1, 32767,  32767,  0,      1, '{-8500, 0, 8500, 0, 1}},
         // all limits zero
         '{2, 32767,  -32768, 32767,  1, NO_SPEED},
         '{2, -32768, 32767,  -32768, 1, NO_SPEED},
         // rotation centre beyond the wheels: mixed-sign lever arms
         '{3, 0,      0,      100,    0, NO_SPEED},
         '{3, 300,    -2000,  32767,  0, NO_SPEED},
         '{3, -5000,  5000,   -32768, 0, NO_SPEED},
         // offsets stored but disabled, full-scale rpm factor
         '{4, 0,      0,      1,      0, NO_SPEED},
         '{4, 1,      1,      0,      0, NO_SPEED},
         '{4, 12,     -7,     -3,     0, NO_SPEED},
         '{4, 32767,  32767,  32767,  0, NO_SPEED},
         // typical chassis
         '{5, 1500,   0,      0,      0, NO_SPEED},
         '{5, 0,      -1500,  0,      0, NO_SPEED},
         '{5, 0,      0,      90,     0, NO_SPEED},
         '{5, 4000,   -4000,  -400,   0, NO_SPEED}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < DIR_PHASES; p++) begin
         if (p != 0) write_config(dir_cfgs[p], 1'b0);
         foreach (dir_rows[r])
            if (dir_rows[r].phase == p) cmd_q.push_back(dir_rows[r]);
         wait_drained();
      end

      left = RANDOM_ITEMS;
      while (left > 0) begin
         cfg = rand_config();
         write_config(cfg, 1'($urandom_range(0, 1)));
         n = $urandom_range(60, 200);
         if (n > left) n = left;
         repeat (n) begin
            item.phase = '0;
            item.fwd = rand_cmd(m_lim_fwd);
            item.side = rand_cmd(m_lim_side);
            item.yaw = rand_cmd(m_lim_yaw);
            item.fixed_want = 1'b0;
            item.want = NO_SPEED;
            cmd_q.push_back(item);
         end
         left -= n;
         wait_drained();
      end

      if (mismatches == 0 && wheel_expect_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mws_pkg.sv
rtl/mws_req_if.sv
rtl/mws_rsp_if.sv
rtl/mws_csr_if.sv
rtl/mws_arm.sv
rtl/mws_div.sv
rtl/mecanum_wheel_speed_solver_core.sv
verif/mecanum_wheel_speed_solver_core_tb.sv
